[rtl/skst_pkg.sv]
`timescale 1ns / 1ps
package skst_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = ADDR_W + 1;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_FIND   = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_OOB       = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SRCH_END,
        S_GET_RD,
        S_GET_CAP,
        S_SHIFT_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_upd;
        logic get_rd;
        logic get_cap;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic ins_wr;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       srch_done;
        logic       hit;
        logic       room;
        logic       idx_ok;
        logic       shift_done;
    } stat_t;

endpackage

[rtl/skst_ram.sv]
`timescale 1ns / 1ps
module skst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/skst_ctrl.sv]
`timescale 1ns / 1ps
module skst_ctrl import skst_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  busy
);

    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    CMD_ADD, CMD_FIND: state_next = S_SRCH_RD;
                    CMD_GET:           state_next = stat.idx_ok ? S_GET_RD : S_DONE;
                    CMD_REMOVE:        state_next = stat.idx_ok ? S_SHIFT_CHK : S_DONE;
                    default:           state_next = S_DONE;
                endcase
            end
            S_SRCH_RD:  state_next = stat.srch_done ? S_SRCH_END : S_SRCH_CMP;
            S_SRCH_CMP: state_next = S_SRCH_RD;
            S_SRCH_END:
            begin
                if (stat.cmd == CMD_ADD && !stat.hit && stat.room)
                begin
                    state_next = S_SHIFT_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_GET_RD:  state_next = S_GET_CAP;
            S_GET_CAP: state_next = S_DONE;
            S_SHIFT_CHK:
            begin
                if (!stat.shift_done)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (stat.cmd == CMD_ADD)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_SHIFT_CHK;
            S_INS_WR:   state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // drive datapath commands
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            S_IDLE:     ctrl.load = start;
            S_DECODE:   ctrl.shift_init = (stat.cmd == CMD_REMOVE) && stat.idx_ok;
            S_SRCH_RD:  ctrl.srch_rd = !stat.srch_done;
            S_SRCH_CMP: ctrl.srch_upd = 1'b1;
            S_SRCH_END: ctrl.shift_init = (stat.cmd == CMD_ADD) && !stat.hit && stat.room;
            S_GET_RD:   ctrl.get_rd = 1'b1;
            S_GET_CAP:  ctrl.get_cap = 1'b1;
            S_SHIFT_CHK: ;
            S_SHIFT_RD: ctrl.shift_rd = 1'b1;
            S_SHIFT_WR: ctrl.shift_wr = 1'b1;
            S_INS_WR:   ctrl.ins_wr = 1'b1;
            S_DONE:     ctrl.finish = 1'b1;
            default:    ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/skst_dp.sv]
`timescale 1ns / 1ps
module skst_dp import skst_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    input  logic [2:0]          command,
    input  logic [KEY_BITS-1:0] key,
    input  logic [ADDR_W-1:0]   index,
    input  ctrl_t               ctrl,
    output stat_t               stat,
    output logic                done,
    output logic [2:0]          status,
    output logic [CNT_W-1:0]    position,
    output logic [KEY_BITS-1:0] key_out,
    output logic [CNT_W-1:0]    entry_count
);

    logic [CNT_W-1:0]    capacity_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [2:0]          cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic                hit_reg;
    logic                ins_reg;
    logic [CNT_W-1:0]    dst_reg;
    logic [KEY_BITS-1:0] get_reg;
    logic                done_reg;
    logic [2:0]          status_reg;
    logic [CNT_W-1:0]    position_reg;
    logic [KEY_BITS-1:0] key_out_reg;
    logic [CNT_W-1:0]    count_out_reg;

    logic [CNT_W:0]      mid_sum;
    logic [CNT_W-1:0]    mid;
    logic [CNT_W-1:0]    limit;
    logic                idx_ok;
    logic [CNT_W-1:0]    dst_up;
    logic [CNT_W-1:0]    dst_dn;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;
    logic [2:0]          status_next;

    // search midpoint and bounds
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign limit   = (capacity_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_reg;
    assign idx_ok  = {1'b0, idx_reg} < count_reg;
    assign dst_up  = dst_reg + 1'b1;
    assign dst_dn  = dst_reg - 1'b1;

    assign stat.cmd        = cmd_reg;
    assign stat.srch_done  = (lo_reg == hi_reg);
    assign stat.hit        = hit_reg;
    assign stat.room       = count_reg < limit;
    assign stat.idx_ok     = idx_ok;
    assign stat.shift_done = (cmd_reg == CMD_ADD) ? (dst_reg == lo_reg)
                                                  : (dst_up == count_reg);

    // select memory addresses
    always_comb
    begin
        ram_raddr = '0;
        if (ctrl.srch_rd)
        begin
            ram_raddr = mid[ADDR_W-1:0];
        end
        else if (ctrl.get_rd)
        begin
            ram_raddr = idx_reg;
        end
        else if (ctrl.shift_rd)
        begin
            ram_raddr = (cmd_reg == CMD_ADD) ? dst_dn[ADDR_W-1:0] : dst_up[ADDR_W-1:0];
        end
    end

    assign ram_we    = ctrl.shift_wr || ctrl.ins_wr;
    assign ram_waddr = ctrl.ins_wr ? lo_reg[ADDR_W-1:0] : dst_reg[ADDR_W-1:0];
    assign ram_wdata = ctrl.ins_wr ? key_reg : ram_rdata;

    skst_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // hold capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CNT_W'(DEPTH);
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    // update entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.ins_wr)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (ctrl.finish && cmd_reg == CMD_CLEAR)
        begin
            count_reg <= '0;
        end
        else if (ctrl.finish && cmd_reg == CMD_REMOVE && idx_ok)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // capture request and run search and shift
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= command;
            key_reg <= key;
            idx_reg <= index;
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            hit_reg <= 1'b0;
            ins_reg <= 1'b0;
        end
        if (ctrl.srch_upd)
        begin
            if (ram_rdata < key_reg)
            begin
                lo_reg <= mid + 1'b1;
            end
            else
            begin
                hi_reg <= mid;
            end
            if (ram_rdata == key_reg)
            begin
                hit_reg <= 1'b1;
            end
        end
        if (ctrl.shift_init)
        begin
            dst_reg <= (cmd_reg == CMD_ADD) ? count_reg : {1'b0, idx_reg};
        end
        if (ctrl.shift_wr)
        begin
            dst_reg <= (cmd_reg == CMD_ADD) ? dst_dn : dst_up;
        end
        if (ctrl.ins_wr)
        begin
            ins_reg <= 1'b1;
        end
        if (ctrl.get_cap)
        begin
            get_reg <= ram_rdata;
        end
    end

    // form result status
    always_comb
    begin
        case (cmd_reg)
            CMD_ADD:            status_next = (hit_reg || ins_reg) ? ST_OK : ST_FULL;
            CMD_FIND:           status_next = hit_reg ? ST_FOUND : ST_NOT_FOUND;
            CMD_GET, CMD_REMOVE: status_next = idx_ok ? ST_OK : ST_OOB;
            CMD_CLEAR:          status_next = ST_OK;
            default:            status_next = ST_OOB;
        endcase
    end

    // strobe result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.finish;
        end
    end

    // register result fields
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            status_reg    <= status_next;
            position_reg  <= (cmd_reg == CMD_ADD || cmd_reg == CMD_FIND) ? lo_reg : '0;
            key_out_reg   <= (cmd_reg == CMD_GET && idx_ok) ? get_reg : '0;
            count_out_reg <= (cmd_reg == CMD_CLEAR) ? '0
                           : (cmd_reg == CMD_REMOVE && idx_ok) ? count_reg - 1'b1
                           : count_reg;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign key_out     = key_out_reg;
    assign entry_count = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_wr |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow count");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.srch_upd |-> lo_reg < hi_reg)
        else $error("search step on empty range");

endmodule

[rtl/sorted_key_set_table.sv]
`timescale 1ns / 1ps
// Sorted key set table: holds up to min(capacity, 64) distinct 32-bit keys in
// ascending order in one simple dual-port RAM. A request is taken when start is
// high and busy is low; its one result appears on the result ports for exactly
// one cycle with done high and must be taken then, since the block cannot be
// held off. Busy stays high through the decode and finish states plus the memory
// work: add and find run read and compare states per halving step of a binary
// search (up to 7 steps at 64 entries) and an end state, get reads and captures
// the entry, remove passes check, read and write states per moved entry, and add
// of a new key does the same and then writes the insert. The result is strobed in
// the cycle in which busy falls, and a new request can be taken at the end of it.
// Capacity is written through cfg_we and cfg_wdata; the user must do so only while the block is idle (not enforced).
module sorted_key_set_table import skst_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          command,
    input  logic [KEY_BITS-1:0] key,
    input  logic [ADDR_W-1:0]   index,
    output logic                done,
    output logic [2:0]          status,
    output logic [CNT_W-1:0]    position,
    output logic [KEY_BITS-1:0] key_out,
    output logic [CNT_W-1:0]    entry_count
);

    ctrl_t ctrl;
    stat_t stat;

    skst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    skst_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .command     (command),
        .key         (key),
        .index       (index),
        .ctrl        (ctrl),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .position    (position),
        .key_out     (key_out),
        .entry_count (entry_count)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without going busy");

endmodule
